FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the sorted task queue. Define ASSERT_OFF to
// compile every check away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge outside reset.
`define STQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside reset.
`define STQ_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define STQ_ASSERT(lbl, clk, rst, prop, msg)
`define STQ_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types, codes and helper functions shared by the sorted task queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Action codes of an input item.
   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_EXTRACT = 2'd1;
   localparam logic [1:0] ACT_PEEK    = 2'd2;
   localparam logic [1:0] ACT_NOP     = 2'd3;

   // Status codes of a result item.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  task_id;
      logic [31:0] sort_key;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  head_id;
      logic [31:0] head_key;
      logic [4:0]  entry_count;
   } rsp_item_type;

   // One stored queue entry.
   typedef struct packed {
      logic [7:0]  task_id;
      logic [31:0] sort_key;
   } entry_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } stq_status_type;

   // Key a beats key b: larger in mode 0, smaller in mode 1.
   function automatic logic beats(input logic mode, input logic [31:0] a,
                                  input logic [31:0] b);
      beats = mode ? (a < b) : (a > b);
   endfunction

   // Physical slot of logical position pos in the ring that starts at head.
   function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      slot_addr = sum[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/stq_seq.sv
// ----------------------------------------------------------------------------
// stq_seq
// Operation sequencer: keeps the ring head and fill count, scans the entry
// memory for the insert position, shifts entries and builds result items.
// ----------------------------------------------------------------------------
module stq_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  stq_pkg::req_item_type   req_item,
   input  logic                    order_mode,
   output logic                    rsp_valid,
   output stq_pkg::rsp_item_type   rsp_item,
   output stq_pkg::stq_status_type status,
   output logic                    ram_wr_en,
   output logic [stq_pkg::IDX_W-1:0] ram_wr_addr,
   output stq_pkg::entry_type      ram_wr_data,
   output logic [stq_pkg::IDX_W-1:0] ram_rd_addr,
   input  stq_pkg::entry_type      ram_rd_data
);
   import stq_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HEAD  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_PLACE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       act_ff, act_in;
   entry_type        new_ff, new_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] ins_pos_ff, ins_pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic [CNT_W-1:0] rd_lpos;
   logic [CNT_W-1:0] nxt_pos;
   logic             scan_on;
   logic             full;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign nxt_pos = rd_pos_ff + CNT_W'(1);

   // Keep scanning while the entry just read ranks ahead of the new one.
   // The head is passed over unless the new entry strictly beats it.
   assign scan_on = (rd_pos_ff == '0) ? !beats(order_mode, new_ff.sort_key,
                                               ram_rd_data.sort_key)
                                      : beats(order_mode, ram_rd_data.sort_key,
                                              new_ff.sort_key);

   // Next-state and memory access logic.
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      new_in       = new_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_pos_in    = rd_pos_ff;
      ins_pos_in   = ins_pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_lpos      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_addr(head_ff, ins_pos_ff);
      ram_wr_data  = new_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in               = req_item.action;
               new_in.task_id       = req_item.task_id;
               new_in.sort_key      = req_item.sort_key;
               rsp_in.status        = ST_OK;
               rsp_in.head_id       = '0;
               rsp_in.head_key      = '0;
               rsp_in.entry_count   = 5'(count_ff);
               unique case (req_item.action)
                  ACT_INSERT: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else if (count_ff == '0) begin
                        // Empty queue: the item becomes the head at once.
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = head_ff;
                        ram_wr_data.task_id  = req_item.task_id;
                        ram_wr_data.sort_key = req_item.sort_key;
                        count_in           = count_ff + CNT_W'(1);
                        rsp_valid_in       = 1'b1;
                        rsp_in.entry_count = 5'(count_ff + CNT_W'(1));
                     end else begin
                        rd_pos_in = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  ACT_EXTRACT, ACT_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_HEAD: begin
            rsp_valid_in       = 1'b1;
            rsp_in.head_id     = ram_rd_data.task_id;
            rsp_in.head_key    = ram_rd_data.sort_key;
            if (act_ff == ACT_EXTRACT) begin
               head_in            = slot_addr(head_ff, CNT_W'(1));
               count_in           = count_ff - CNT_W'(1);
               rsp_in.entry_count = 5'(count_ff - CNT_W'(1));
            end
            state_in = S_IDLE;
         end

         S_SCAN: begin
            if (scan_on && (nxt_pos < count_ff)) begin
               rd_lpos   = nxt_pos;
               rd_pos_in = nxt_pos;
            end else begin
               ins_pos_in = scan_on ? nxt_pos : rd_pos_ff;
               if ((scan_on ? nxt_pos : rd_pos_ff) == count_ff) begin
                  state_in = S_PLACE;
               end else begin
                  // Shift the tail back by one, last entry first.
                  rd_lpos   = count_ff - CNT_W'(1);
                  rd_pos_in = count_ff - CNT_W'(1);
                  state_in  = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_addr(head_ff, nxt_pos);
            ram_wr_data = ram_rd_data;
            if (rd_pos_ff == ins_pos_ff) begin
               state_in = S_PLACE;
            end else begin
               rd_lpos   = rd_pos_ff - CNT_W'(1);
               rd_pos_in = rd_pos_ff - CNT_W'(1);
            end
         end

         S_PLACE: begin
            ram_wr_en          = 1'b1;
            count_in           = count_ff + CNT_W'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.entry_count = 5'(count_ff + CNT_W'(1));
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ram_rd_addr = slot_addr(head_ff, rd_lpos);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      new_ff     <= new_in;
      rd_pos_ff  <= rd_pos_in;
      ins_pos_ff <= ins_pos_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_ff;
   assign status.busy  = (state_ff != S_IDLE);
   assign status.count = count_ff;

endmodule

FILE: rtl/sorted_task_queue.sv
// ----------------------------------------------------------------------------
// sorted_task_queue
// Bounded queue of task entries kept sorted by the order mode register.
// Nop, full insert, empty extract/peek and insert into an empty queue answer
// in the cycle after acceptance with busy staying low; extract and peek first
// read the head. Other inserts scan for the insert position, shift the tail
// and place the item; one item at a time, no result stall.
// Synchronous reset empties the queue and sets order mode to 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_task_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  stq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output stq_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic                  csr_wdata
);
   import stq_pkg::*;

   logic             order_mode_ff, order_mode_in;
   stq_status_type   seq_status;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_wr_data;
   entry_type        ram_rd_data;
   logic             accept;

   assign accept = start && !busy;

   // Order mode register.
   assign order_mode_in = csr_we ? csr_wdata : order_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= 1'b0;
      end else begin
         order_mode_ff <= order_mode_in;
      end
   end

   // Sequencer.
   stq_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .req_item    (req_item),
      .order_mode  (order_mode_ff),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .status      (seq_status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Entry memory, one ring slot per entry.
   stq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy = seq_status.busy;

   // An accepted item either answers in the next cycle or keeps the block busy.
   `STQ_ASSERT(a_accept_progress, clock, reset,
               accept |=> (rsp_valid || busy), "item lost")
   // Leaving a multi-cycle operation always delivers its result.
   `STQ_ASSERT(a_done_responds, clock, reset, $fell(busy) |-> rsp_valid, "missing result")
   // A full status only comes from a queue that is really full.
   `STQ_ASSERT(a_full_count, clock, reset,
               (rsp_valid && rsp_item.status == ST_FULL) |->
               (seq_status.count == CNT_W'(QUEUE_DEPTH)), "bad full status")
   // The fill count never exceeds the queue depth.
   `STQ_NEVER(a_count_range, clock, reset,
              seq_status.count > CNT_W'(QUEUE_DEPTH), "count overflow")

endmodule

FILE: dv/sorted_task_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_task_queue_tb
// Self-checking testbench for the sorted task queue. A clocked driver feeds
// insert, extract, peek and nop items from a backlog, and a clocked monitor
// compares every result item with a prediction made when its item was
// accepted. Runs a directed part and then random bursts in both order modes,
// with varying sender gaps and at least one pause until the queue has
// answered everything outstanding.
// ----------------------------------------------------------------------------
module sorted_task_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stq_pkg::*;

   // One item waiting to be driven, optionally held until all results are in.
   typedef struct {
      req_item_type item;
      bit           wait_drain;
   } backlog_entry_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         start     = 1'b0;
   logic         busy;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_we    = 1'b0;
   logic         csr_wdata = 1'b0;

   backlog_entry_type req_backlog[$];
   rsp_item_type      predicted_rsps[$];
   int                send_idle_pct  = 0;
   int                mismatch_count = 0;

   // Shadow copy of the queue contents and the order mode.
   logic [7:0]  shadow_ids [QUEUE_DEPTH];
   logic [31:0] shadow_keys[QUEUE_DEPTH];
   int          shadow_count = 0;
   logic        shadow_mode  = 1'b0;

   sorted_task_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // True when key a ranks ahead of key b in the current order mode.
   function automatic bit key_wins(input logic [31:0] a, input logic [31:0] b);
      return shadow_mode ? (a < b) : (a > b);
   endfunction

   // Applies one item to the shadow queue and returns the result it causes.
   function automatic rsp_item_type apply_queue_op(input req_item_type op);
      rsp_item_type res;
      int           pos;
      int           i;
      res = '0;
      res.status = ST_OK;
      case (op.action)
         ACT_INSERT: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // New head only on a strict win; otherwise scan from slot 1.
               if (shadow_count == 0 || key_wins(op.sort_key, shadow_keys[0])) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < shadow_count && key_wins(shadow_keys[pos], op.sort_key))
                     pos++;
               end
               for (i = shadow_count; i > pos; i--) begin
                  shadow_ids[i]  = shadow_ids[i-1];
                  shadow_keys[i] = shadow_keys[i-1];
               end
               shadow_ids[pos]  = op.task_id;
               shadow_keys[pos] = op.sort_key;
               shadow_count++;
            end
         end
         ACT_EXTRACT, ACT_PEEK: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.head_id  = shadow_ids[0];
               res.head_key = shadow_keys[0];
               if (op.action == ACT_EXTRACT) begin
                  for (i = 1; i < shadow_count; i++) begin
                     shadow_ids[i-1]  = shadow_ids[i];
                     shadow_keys[i-1] = shadow_keys[i];
                  end
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      res.entry_count = 5'(shadow_count);
      return res;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Driver: records accepted items and presents the next one from the backlog.
   always @(posedge clock) begin : driver
      bit                hold_for_drain;
      backlog_entry_type next_entry;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_rsps.push_back(apply_queue_op(req_item));
         end
         if (!(start && busy)) begin
            hold_for_drain = req_backlog.size() > 0 && req_backlog[0].wait_drain &&
                             (predicted_rsps.size() > 0 || rsp_valid);
            if (req_backlog.size() > 0 && !hold_for_drain &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               next_entry = req_backlog.pop_front();
               start    <= 1'b1;
               req_item <= next_entry.item;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every result item is checked against the oldest prediction.
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (predicted_rsps.size() == 0) begin
            report_mismatch("result with nothing outstanding, status",
                            32'(rsp_item.status), 32'd0);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
            if (rsp_item.head_id !== want.head_id)
               report_mismatch("head_id", 32'(rsp_item.head_id), 32'(want.head_id));
            if (rsp_item.head_key !== want.head_key)
               report_mismatch("head_key", rsp_item.head_key, want.head_key);
            if (rsp_item.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_item.entry_count),
                               32'(want.entry_count));
         end
      end
   end

   // Queues one item for the driver.
   task automatic push_item(input logic [1:0] action, input logic [7:0] id,
                            input logic [31:0] key, input bit wait_drain);
      backlog_entry_type entry;
      entry.item.action   = action;
      entry.item.task_id  = id;
      entry.item.sort_key = key;
      entry.wait_drain    = wait_drain;
      req_backlog.push_back(entry);
   endtask

   // Waits until the block has answered everything and is quiet.
   task automatic wait_idle();
      do
         @(posedge clock);
      while (req_backlog.size() != 0 || start || predicted_rsps.size() != 0 || rsp_valid);
      repeat (40) @(posedge clock);
   endtask

   // Writes the order mode; only called while the block is idle.
   task automatic write_order_mode(input logic mode);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= 1'b0;
      shadow_mode = mode;
   endtask

   // Keys lean toward the extremes and small values so that ties are common.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'($urandom_range(0, 7));
         3:       return 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   // Random bursts, each with its own insert bias so the queue fills and drains.
   task automatic push_random(input int count);
      int insert_pct;
      int n;
      int r;
      logic [1:0] action;
      insert_pct = 50;
      for (n = 0; n < count; n++) begin
         if (n % 24 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         if ($urandom_range(0, 99) < insert_pct) begin
            action = ACT_INSERT;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70)      action = ACT_EXTRACT;
            else if (r < 95) action = ACT_PEEK;
            else             action = ACT_NOP;
         end
         push_item(action, 8'($urandom_range(0, 255)), pick_key(),
                   n == count / 2 || $urandom_range(0, 39) == 0);
      end
   endtask

   // Stimulus sequence.
   initial begin : stimulus
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_order_mode(1'b0);

      // Directed part in descending mode: empty queue, extremes, ties, full.
      send_idle_pct = 24;
      push_item(ACT_EXTRACT, 8'h00, 32'h0, 1'b0);
      push_item(ACT_PEEK,    8'hFF, 32'hFFFF_FFFF, 1'b0);
      push_item(ACT_NOP,     8'hFF, 32'hFFFF_FFFF, 1'b0);
      push_item(ACT_INSERT,  8'h00, 32'h0000_0000, 1'b0);
      push_item(ACT_INSERT,  8'hFF, 32'hFFFF_FFFF, 1'b0);
      push_item(ACT_INSERT,  8'h01, 32'h0000_0000, 1'b0);
      push_item(ACT_INSERT,  8'h02, 32'h0000_0005, 1'b0);
      push_item(ACT_PEEK,    8'h00, 32'h0, 1'b0);
      for (k = 0; k < 12; k++)
         push_item(ACT_INSERT, 8'(16 + k), (k % 3 == 0) ? 32'h0000_0007 : pick_key(), 1'b0);
      push_item(ACT_INSERT,  8'hAA, 32'hFFFF_FFFF, 1'b0);
      push_item(ACT_NOP,     8'h00, 32'h0, 1'b0);
      push_item(ACT_PEEK,    8'h00, 32'h0, 1'b0);
      push_item(ACT_EXTRACT, 8'h00, 32'h0, 1'b0);
      push_item(ACT_EXTRACT, 8'h00, 32'h0, 1'b0);
      push_random(180);
      wait_idle();

      // Ascending mode with entries still held, sparse sender.
      write_order_mode(1'b1);
      send_idle_pct = 79;
      push_random(180);
      wait_idle();

      // Back to descending, back to back.
      write_order_mode(1'b0);
      send_idle_pct = 0;
      push_random(100);
      wait_idle();

      write_order_mode(1'b1);
      push_random(90);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("sorted_task_queue verification clean");
      end else begin
         $display("sorted_task_queue verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("sorted_task_queue verification failed");
      $finish;
   end

endmodule

FILE: sorted_task_queue.f
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_seq.sv
rtl/sorted_task_queue.sv
dv/sorted_task_queue_tb.sv
